/* hw/rtl/nsv_pkg.sv */
package nsv_pkg;

   // Line buffer size in bytes; a byte that would fill the last slot drops the line.
   localparam int unsigned LineBufferBytes = 256;
   localparam logic [8:0] LineLimit = 9'(LineBufferBytes);

   localparam logic [7:0] MinLineBytes   = 8'd6;
   localparam logic [7:0] MaxLineBytes   = 8'd160;
   localparam logic [2:0] HeaderBytes    = 3'd6;
   localparam logic [2:0] HeaderSatLimit = 3'd7;

   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharComma  = 8'h2C;

   localparam logic [23:0] TypeGga = 24'h474741;
   localparam logic [23:0] TypeRmc = 24'h524D43;
   localparam logic [23:0] TypeGsv = 24'h475356;

   localparam logic [15:0] TalkGp = 16'h4750;
   localparam logic [15:0] TalkGl = 16'h474C;
   localparam logic [15:0] TalkGa = 16'h4741;
   localparam logic [15:0] TalkBd = 16'h4244;
   localparam logic [15:0] TalkGn = 16'h474E;

   typedef enum logic [2:0] {
      VERDICT_GGA          = 3'd0,
      VERDICT_RMC          = 3'd1,
      VERDICT_GSV          = 3'd2,
      VERDICT_OTHER        = 3'd3,
      VERDICT_SHORT        = 3'd4,
      VERDICT_BAD_SUM      = 3'd5,
      VERDICT_TOO_LONG     = 3'd6,
      VERDICT_SHORT_HEADER = 3'd7
   } verdict_type;

   typedef enum logic [2:0] {
      TALKER_GP      = 3'd0,
      TALKER_GL      = 3'd1,
      TALKER_GA      = 3'd2,
      TALKER_BD      = 3'd3,
      TALKER_GN      = 3'd4,
      TALKER_UNKNOWN = 3'd5
   } talker_type;

   typedef struct packed {
      logic [7:0]  byte_count;
      logic        starts_with_dollar;
      logic [7:0]  running_xor;
      logic        star_found;
      logic [7:0]  star_index;
      logic [7:0]  expected_sum;
      logic        hex_invalid;
      logic [2:0]  header_length;
      logic        header_closed;
      logic [15:0] talker_chars;
      logic [23:0] type_chars;
   } line_state_type;

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/nmea_sentence_validator_core.sv */
// Pipeline: a byte is registered on acceptance; a line terminator's result is loaded
// into the result register when the terminator advances out of the input register,
// which raises rsp_valid; the result is held there until the consumer takes it.
// Throughput: one byte per cycle; the only stall is a terminator waiting on a full
// result register that the consumer has not drained.
// Reset (synchronous, active high) empties both registers and clears the line state.
module nmea_sentence_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_verdict,
   output logic [2:0] rsp_talker_slot,
   output logic [7:0] rsp_computed_checksum,
   output logic [7:0] rsp_line_length
);

   // Input register: holds one received byte until the line tracker takes it.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // Result register.
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [2:0] out_verdict_ff;
   logic [2:0] out_talker_ff;
   logic [7:0] out_sum_ff;
   logic [7:0] out_len_ff;

   nsv_pkg::line_state_type line_state;
   nsv_pkg::verdict_type    verdict;
   nsv_pkg::talker_type     talker_slot;

   logic is_term;
   logic emit;
   logic out_free;
   logic advance;

   // Line state update for the registered byte.
   nsv_line_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .line_state (line_state)
   );

   // Classify the line as it stands before the terminator clears it.
   nsv_verdict u_verdict (
      .line_state  (line_state),
      .verdict     (verdict),
      .talker_slot (talker_slot)
   );

   always_comb begin
      is_term  = (in_byte_ff == nsv_pkg::CharCr) || (in_byte_ff == nsv_pkg::CharLf);
      // Only a terminator that closes a non-empty line produces a result.
      emit     = in_valid_ff && is_term && (line_state.byte_count != 8'd0);
      out_free = !out_valid_ff || rsp_ready;
      // Advance the registered byte unless its result has nowhere to go.
      advance  = in_valid_ff && (!emit || out_free);
      req_ready = !in_valid_ff || advance;

      in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = (emit && advance) ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on acceptance, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
      if (emit && advance) begin
         out_verdict_ff <= verdict;
         out_talker_ff  <= talker_slot;
         out_sum_ff     <= line_state.running_xor;
         out_len_ff     <= line_state.byte_count;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_verdict           = out_verdict_ff;
   assign rsp_talker_slot       = out_talker_ff;
   assign rsp_computed_checksum = out_sum_ff;
   assign rsp_line_length       = out_len_ff;

   // A reported line is never empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_length != 8'd0)
      else $error("empty line reported");

   // A valid sentence verdict implies at least the minimum length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict <= 3'(nsv_pkg::VERDICT_OTHER))
         |-> rsp_line_length >= nsv_pkg::MinLineBytes)
      else $error("valid verdict on short line");

   // Too-long verdict only for lines at or past the limit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict == 3'(nsv_pkg::VERDICT_TOO_LONG))
         |-> rsp_line_length >= nsv_pkg::MaxLineBytes)
      else $error("too-long verdict on short line");

   // Consuming a terminator leaves the line state empty.
   assert property (@(posedge clock) disable iff (reset)
      (advance && is_term) |=> line_state.byte_count == 8'd0)
      else $error("line state not cleared after terminator");

endmodule

/* hw/rtl/nsv_line_tracker.sv */
module nsv_line_tracker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   output nsv_pkg::line_state_type line_state
);

   nsv_pkg::line_state_type state_ff;
   nsv_pkg::line_state_type state_in;

   logic       is_term;
   logic       overflow;
   logic [8:0] pos9;
   logic [8:0] star_p1;
   logic [8:0] star_p2;
   logic [4:0] hex;

   assign line_state = state_ff;

   always_comb begin
      is_term  = (data_byte == nsv_pkg::CharCr) || (data_byte == nsv_pkg::CharLf);
      pos9     = {1'b0, state_ff.byte_count};
      overflow = (pos9 + 9'd1) >= nsv_pkg::LineLimit;
      star_p1  = {1'b0, state_ff.star_index} + 9'd1;
      star_p2  = {1'b0, state_ff.star_index} + 9'd2;
      hex      = nsv_pkg::hex_digit(data_byte);
      state_in = state_ff;

      if (is_term || overflow) begin
         // End or drop the line: clear everything.
         state_in = '0;
      end else begin
         if (state_ff.byte_count == 8'd0) begin
            state_in.starts_with_dollar = (data_byte == nsv_pkg::CharDollar);
         end
         if (state_ff.byte_count == 8'd1 || state_ff.byte_count == 8'd2) begin
            state_in.talker_chars = {state_ff.talker_chars[7:0], data_byte};
         end
         if (state_ff.byte_count >= 8'd3 && state_ff.byte_count <= 8'd5) begin
            state_in.type_chars = {state_ff.type_chars[15:0], data_byte};
         end

         if (!state_ff.header_closed) begin
            if (data_byte == nsv_pkg::CharComma || data_byte == nsv_pkg::CharStar) begin
               state_in.header_closed = 1'b1;
            end else if (state_ff.header_length < nsv_pkg::HeaderSatLimit) begin
               state_in.header_length = state_ff.header_length + 3'd1;
            end
         end

         if (state_ff.star_found) begin
            if (pos9 == star_p1 || pos9 == star_p2) begin
               if (!hex[4]) begin
                  state_in.hex_invalid = 1'b1;
               end else begin
                  state_in.expected_sum = {state_ff.expected_sum[3:0], hex[3:0]};
               end
            end
         end else if (data_byte == nsv_pkg::CharStar) begin
            state_in.star_found = 1'b1;
            state_in.star_index = state_ff.byte_count;
         end else if (state_ff.byte_count != 8'd0) begin
            state_in.running_xor = state_ff.running_xor ^ data_byte;
         end

         state_in.byte_count = state_ff.byte_count + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/nsv_verdict.sv */
module nsv_verdict (
   input  nsv_pkg::line_state_type line_state,
   output nsv_pkg::verdict_type    verdict,
   output nsv_pkg::talker_type     talker_slot
);

   logic       sum_ok;
   logic [9:0] star_p3;

   always_comb begin
      star_p3 = {2'b00, line_state.star_index} + 10'd3;
      sum_ok  = line_state.star_found && (line_state.star_index != 8'd0) &&
                ({2'b00, line_state.byte_count} >= star_p3) &&
                !line_state.hex_invalid &&
                (line_state.expected_sum == line_state.running_xor);

      if (line_state.byte_count < nsv_pkg::MinLineBytes || !line_state.starts_with_dollar) begin
         verdict = nsv_pkg::VERDICT_SHORT;
      end else if (!sum_ok) begin
         verdict = nsv_pkg::VERDICT_BAD_SUM;
      end else if (line_state.byte_count >= nsv_pkg::MaxLineBytes) begin
         verdict = nsv_pkg::VERDICT_TOO_LONG;
      end else if (line_state.header_length < nsv_pkg::HeaderBytes) begin
         verdict = nsv_pkg::VERDICT_SHORT_HEADER;
      end else if (line_state.header_length == nsv_pkg::HeaderBytes &&
                   line_state.type_chars == nsv_pkg::TypeGga) begin
         verdict = nsv_pkg::VERDICT_GGA;
      end else if (line_state.header_length == nsv_pkg::HeaderBytes &&
                   line_state.type_chars == nsv_pkg::TypeRmc) begin
         verdict = nsv_pkg::VERDICT_RMC;
      end else if (line_state.header_length == nsv_pkg::HeaderBytes &&
                   line_state.type_chars == nsv_pkg::TypeGsv) begin
         verdict = nsv_pkg::VERDICT_GSV;
      end else begin
         verdict = nsv_pkg::VERDICT_OTHER;
      end

      case (line_state.talker_chars)
         nsv_pkg::TalkGp: talker_slot = nsv_pkg::TALKER_GP;
         nsv_pkg::TalkGl: talker_slot = nsv_pkg::TALKER_GL;
         nsv_pkg::TalkGa: talker_slot = nsv_pkg::TALKER_GA;
         nsv_pkg::TalkBd: talker_slot = nsv_pkg::TALKER_BD;
         nsv_pkg::TalkGn: talker_slot = nsv_pkg::TALKER_GN;
         default:         talker_slot = nsv_pkg::TALKER_UNKNOWN;
      endcase
   end

endmodule
